// ----- rtl/rgbf_pkg.sv -----
`timescale 1ns / 1ps
// shared types and constants for the rgba linear fade ramp
// no dependencies; imported by rgbf_div and rgba_linear_fade_ramp
package rgbf_pkg;

   localparam int COLOR_W   = 8;
   localparam int NUM_CH    = 4;
   localparam int CH_W      = 2;
   localparam int TICK_W    = 9;
   localparam int TICK_MAX  = 306;

   // x / 5 as (x * 205) >> 10, exact for x below 1024
   localparam int MARGIN_MUL   = 205;
   localparam int MARGIN_SHIFT = 10;
   localparam int MARGIN_PW    = 16;
   localparam int MARGIN_W     = 6;

   localparam logic [COLOR_W-1:0] STEP_RESET = 8'd100;

   typedef enum logic {
      CMD_START = 1'b0,
      CMD_TICK  = 1'b1
   } cmd_type;

   typedef struct packed {
      logic               start;
      logic [COLOR_W-1:0] dividend;
      logic [COLOR_W-1:0] divisor;
   } div_req_type;

endpackage

// ----- rtl/rgbf_div.sv -----
`timescale 1ns / 1ps
// restoring divider, one quotient bit a cycle: (dividend << FRAC_BITS) / divisor
// depends on rgbf_pkg
module rgbf_div import rgbf_pkg::*; #(
   parameter int FRAC_BITS = 16
) (
   input  logic                           clock,
   input  logic                           reset,
   input  div_req_type                    div_req,
   output logic                           div_done,
   output logic [COLOR_W+FRAC_BITS-1:0]   div_quot
);

   localparam int Q_W   = COLOR_W + FRAC_BITS;
   localparam int CNT_W = $clog2(Q_W + 1);

   logic               busy_ff;
   logic               done_ff;
   logic [CNT_W-1:0]   cnt_ff;
   logic [Q_W-1:0]     work_ff;
   logic [COLOR_W-1:0] rem_ff;
   logic [COLOR_W-1:0] dsr_ff;

   logic [COLOR_W:0]   trial;
   logic               ge;
   logic [COLOR_W:0]   diff;
   logic [COLOR_W-1:0] rem_in;
   logic [Q_W-1:0]     work_in;

   always_comb begin
      trial   = {rem_ff, work_ff[Q_W-1]};
      ge      = trial >= {1'b0, dsr_ff};
      diff    = trial - {1'b0, dsr_ff};
      rem_in  = ge ? diff[COLOR_W-1:0] : trial[COLOR_W-1:0];
      work_in = {work_ff[Q_W-2:0], ge};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         // done pulses for one cycle after the last quotient bit
         done_ff <= !div_req.start && busy_ff && (cnt_ff == CNT_W'(Q_W - 1));
         if (div_req.start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= '0;
            work_ff <= {div_req.dividend, {FRAC_BITS{1'b0}}};
            rem_ff  <= '0;
            dsr_ff  <= div_req.divisor;
         end else if (busy_ff) begin
            work_ff <= work_in;
            rem_ff  <= rem_in;
            cnt_ff  <= cnt_ff + 1'b1;
            if (cnt_ff == CNT_W'(Q_W - 1)) begin
               busy_ff <= 1'b0;
            end
         end
      end
   end

   assign div_done = done_ff;
   assign div_quot = work_ff;

endmodule

// ----- rtl/rgba_linear_fade_ramp.sv -----
`timescale 1ns / 1ps
// rgba linear fade ramp: sequencer, channel registers and result register
// depends on rgbf_pkg and rgbf_div
//
//  channel | ports                          | direction | handshake
//  --------+--------------------------------+-----------+----------------------
//  req     | req_cmd, req_from_*, req_to_*, | in        | req_valid / req_stall
//          | req_rising                     |           |
//  rsp     | rsp_red .. rsp_alpha, rsp_last | out       | rsp_valid / rsp_stall
//  csr     | csr_step_count                 | in        | csr_valid / csr_ready
//
// a start item works out each channel's increment with the one shared bit-serial divider,
// which works through the channels in turn
// a ramp tick steps each channel in turn through the shared add and clamp, then hands
// the item to the result register from the emit state; the final tick goes straight to emit
// req_stall is high whenever the sequencer is not idle
// reset (synchronous, active high) leaves the block idle with step count 100
// a waiting result does not block the next item; only the move into the result
// register waits for rsp_stall to drop
module rgba_linear_fade_ramp import rgbf_pkg::*; #(
   parameter int FRAC_BITS = 16
) (
   input  logic               clock,
   input  logic               reset,

   input  logic               req_valid,
   output logic               req_stall,
   input  logic               req_cmd,
   input  logic [COLOR_W-1:0] req_from_red,
   input  logic [COLOR_W-1:0] req_from_green,
   input  logic [COLOR_W-1:0] req_from_blue,
   input  logic [COLOR_W-1:0] req_from_alpha,
   input  logic [COLOR_W-1:0] req_to_red,
   input  logic [COLOR_W-1:0] req_to_green,
   input  logic [COLOR_W-1:0] req_to_blue,
   input  logic [COLOR_W-1:0] req_to_alpha,
   input  logic               req_rising,

   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [COLOR_W-1:0] rsp_red,
   output logic [COLOR_W-1:0] rsp_green,
   output logic [COLOR_W-1:0] rsp_blue,
   output logic [COLOR_W-1:0] rsp_alpha,
   output logic               rsp_last,

   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic [COLOR_W-1:0] csr_step_count
);

   localparam int Q_W   = COLOR_W + FRAC_BITS;   // quotient magnitude
   localparam int INC_W = Q_W + 1;               // signed increment
   localparam int ACC_W = FRAC_BITS + 10;        // signed accumulator, room for overshoot

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DIV_GO,
      ST_DIV_WAIT,
      ST_TICK,
      ST_EMIT
   } state_type;

   state_type                 state_ff;
   logic [CH_W-1:0]           ch_ff;
   logic                      active_ff;
   logic                      rising_ff;
   logic [TICK_W-1:0]         tick_cnt_ff;
   logic [COLOR_W-1:0]        step_ff;
   logic                      div_start_ff;
   logic                      last_pend_ff;

   logic signed [ACC_W-1:0]   acc_ff  [NUM_CH];
   logic signed [INC_W-1:0]   inc_ff  [NUM_CH];
   logic [COLOR_W-1:0]        tgt_ff  [NUM_CH];
   logic [COLOR_W-1:0]        pix_ff  [NUM_CH];

   logic                      rsp_valid_ff;
   logic                      rsp_last_ff;
   logic [COLOR_W-1:0]        rsp_pix_ff [NUM_CH];

   // effective step count and ramp length (steps plus a fifth)
   logic [COLOR_W-1:0]        step_eff;
   logic [MARGIN_PW-1:0]      margin_prod;
   logic [MARGIN_W-1:0]       margin;
   logic [TICK_W-1:0]         ramp_ticks;

   // shared per-channel unit
   logic [COLOR_W-1:0]        from_sel;
   logic [COLOR_W-1:0]        tgt_sel;
   logic                      down_sel;
   logic [COLOR_W-1:0]        mag_sel;
   logic signed [ACC_W-1:0]   sum;
   logic signed [ACC_W-1:0]   lim;
   logic                      clamp;
   logic [COLOR_W-1:0]        byte_out;
   logic signed [INC_W-1:0]   inc_new;

   div_req_type               div_req;
   logic                      div_done;
   logic [Q_W-1:0]            div_quot;

   logic                      req_take;
   logic                      rsp_free;

   always_comb begin
      step_eff    = (step_ff == '0) ? COLOR_W'(1) : step_ff;
      margin_prod = MARGIN_PW'(step_eff) * MARGIN_PW'(MARGIN_MUL);
      margin      = margin_prod[MARGIN_SHIFT +: MARGIN_W];
      ramp_ticks  = TICK_W'(step_eff) + TICK_W'(margin);
   end

   // before the ramp starts the accumulator still holds the from colour
   always_comb begin
      from_sel = acc_ff[ch_ff][FRAC_BITS +: COLOR_W];
      tgt_sel  = tgt_ff[ch_ff];
      down_sel = tgt_sel < from_sel;
      mag_sel  = down_sel ? (from_sel - tgt_sel) : (tgt_sel - from_sel);
      inc_new  = down_sel ? -$signed({1'b0, div_quot}) : $signed({1'b0, div_quot});
   end

   // add increment, then clamp against the target on the latched side
   always_comb begin
      sum      = acc_ff[ch_ff] + ACC_W'(inc_ff[ch_ff]);
      lim      = $signed({2'b00, tgt_sel, {FRAC_BITS{1'b0}}});
      clamp    = rising_ff ? (sum > lim) : (sum < lim);
      byte_out = clamp ? tgt_sel : sum[FRAC_BITS +: COLOR_W];
   end

   always_comb begin
      div_req.start    = div_start_ff;
      div_req.dividend = mag_sel;
      div_req.divisor  = step_eff;
   end

   rgbf_div #(
      .FRAC_BITS (FRAC_BITS)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .div_req  (div_req),
      .div_done (div_done),
      .div_quot (div_quot)
   );

   assign req_stall = (state_ff != ST_IDLE);
   assign req_take  = req_valid && !req_stall;
   assign rsp_free  = !rsp_valid_ff || !rsp_stall;
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         ch_ff        <= '0;
         active_ff    <= 1'b0;
         rising_ff    <= 1'b0;
         tick_cnt_ff  <= '0;
         step_ff      <= STEP_RESET;
         div_start_ff <= 1'b0;
         last_pend_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         // one-cycle divider start from the go state
         div_start_ff <= (state_ff == ST_DIV_GO);
         if (csr_valid && csr_ready) begin
            step_ff <= csr_step_count;
         end
         // the emit state reloads the result register itself
         if (rsp_valid_ff && !rsp_stall && (state_ff != ST_EMIT)) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            ST_IDLE: begin
               if (req_take) begin
                  if (req_cmd == CMD_START) begin
                     // load from colours and targets, then work out increments
                     acc_ff[0]   <= $signed({2'b00, req_from_red,   {FRAC_BITS{1'b0}}});
                     acc_ff[1]   <= $signed({2'b00, req_from_green, {FRAC_BITS{1'b0}}});
                     acc_ff[2]   <= $signed({2'b00, req_from_blue,  {FRAC_BITS{1'b0}}});
                     acc_ff[3]   <= $signed({2'b00, req_from_alpha, {FRAC_BITS{1'b0}}});
                     tgt_ff[0]   <= req_to_red;
                     tgt_ff[1]   <= req_to_green;
                     tgt_ff[2]   <= req_to_blue;
                     tgt_ff[3]   <= req_to_alpha;
                     rising_ff   <= req_rising;
                     tick_cnt_ff <= '0;
                     active_ff   <= 1'b1;
                     ch_ff       <= '0;
                     state_ff    <= ST_DIV_GO;
                  end else if (active_ff) begin
                     if (tick_cnt_ff < ramp_ticks) begin
                        ch_ff        <= '0;
                        last_pend_ff <= 1'b0;
                        state_ff     <= ST_TICK;
                     end else begin
                        // fade over: exact target, marked last
                        for (int c = 0; c < NUM_CH; c++) begin
                           pix_ff[c] <= tgt_ff[c];
                        end
                        last_pend_ff <= 1'b1;
                        active_ff    <= 1'b0;
                        state_ff     <= ST_EMIT;
                     end
                  end
                  // tick while idle: nothing to do
               end
            end
            ST_DIV_GO: begin
               state_ff <= ST_DIV_WAIT;
            end
            ST_DIV_WAIT: begin
               if (div_done) begin
                  inc_ff[ch_ff] <= inc_new;
                  if (ch_ff == CH_W'(NUM_CH - 1)) begin
                     state_ff <= ST_IDLE;
                  end else begin
                     ch_ff    <= ch_ff + 1'b1;
                     state_ff <= ST_DIV_GO;
                  end
               end
            end
            ST_TICK: begin
               acc_ff[ch_ff] <= sum;
               pix_ff[ch_ff] <= byte_out;
               if (ch_ff == CH_W'(NUM_CH - 1)) begin
                  tick_cnt_ff <= tick_cnt_ff + 1'b1;
                  state_ff    <= ST_EMIT;
               end else begin
                  ch_ff <= ch_ff + 1'b1;
               end
            end
            ST_EMIT: begin
               if (rsp_free) begin
                  for (int c = 0; c < NUM_CH; c++) begin
                     rsp_pix_ff[c] <= pix_ff[c];
                  end
                  rsp_last_ff  <= last_pend_ff;
                  rsp_valid_ff <= 1'b1;
                  state_ff     <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_last  = rsp_last_ff;
   assign rsp_red   = rsp_pix_ff[0];
   assign rsp_green = rsp_pix_ff[1];
   assign rsp_blue  = rsp_pix_ff[2];
   assign rsp_alpha = rsp_pix_ff[3];

`ifndef ASSERT_OFF
   // divider finishes only while the sequencer waits for it
   a_div_done_wait: assert property (@(posedge clock) disable iff (reset)
      div_done |-> (state_ff == ST_DIV_WAIT))
      else $error("divider done outside wait state");

   // a divider start always comes from the go state
   a_div_start_go: assert property (@(posedge clock) disable iff (reset)
      div_start_ff |-> ($past(state_ff) == ST_DIV_GO))
      else $error("divider started from wrong state");

   // tick counter never passes the longest ramp
   a_tick_bound: assert property (@(posedge clock) disable iff (reset)
      tick_cnt_ff <= TICK_W'(TICK_MAX))
      else $error("tick count beyond ramp length");

   // a result loaded from the emit state becomes valid next cycle
   a_emit_load: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_EMIT) && rsp_free |=> rsp_valid && (state_ff == ST_IDLE))
      else $error("emit did not load result register");
`endif

endmodule
